@@ rtl/core/cfvt_pkg.sv @@
// ----------------------------------------------------------------------------
// cfvt_pkg
// Shared types, constants and the CAN identifier map of the frame-to-table
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package cfvt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);

	typedef enum logic {
		OP_FRAME = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		logic        op;
		logic [10:0] can_id;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [7:0]  byte3;
		logic [7:0]  byte4;
		logic [7:0]  byte5;
		logic [7:0]  byte6;
		logic [7:0]  byte7;
		logic [7:0]  read_index;
	} item_t;

	typedef struct packed {
		logic        id_known;
		logic [7:0]  first_entry;
		logic [2:0]  words_written;
		logic [15:0] read_value;
	} result_t;

	// One row of the identifier map
	typedef struct packed {
		logic       known;
		logic [7:0] first;
		logic [2:0] count;
		logic       sp2;
	} map_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic wr;
		logic rd;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_rd;
		logic in_known;
		logic last_word;
	} dp_sts_t;

	function automatic map_t row(input logic [7:0] first, input logic [2:0] count,
			input logic sp2);
		map_t r;
		r.known = 1'b1;
		r.first = first;
		r.count = count;
		r.sp2   = sp2;
		return r;
	endfunction

	function automatic map_t map_lookup(input logic [10:0] id);
		map_t m;
		m = '0;
		case (id)
			11'h030: m = row(8'd1,  3'd4, 1'b0);
			11'h031: m = row(8'd5,  3'd4, 1'b0);
			11'h032: m = row(8'd9,  3'd4, 1'b0);
			11'h040: m = row(8'd13, 3'd4, 1'b0);
			11'h041: m = row(8'd17, 3'd4, 1'b0);
			11'h042: m = row(8'd21, 3'd4, 1'b0);
			11'h050: m = row(8'd25, 3'd2, 1'b1);
			11'h060: m = row(8'd26, 3'd2, 1'b1);
			11'h070: m = row(8'd29, 3'd1, 1'b0);
			11'h080: m = row(8'd30, 3'd4, 1'b0);
			11'h081: m = row(8'd34, 3'd4, 1'b0);
			11'h082: m = row(8'd38, 3'd4, 1'b0);
			11'h090: m = row(8'd42, 3'd4, 1'b0);
			11'h091: m = row(8'd46, 3'd4, 1'b0);
			11'h092: m = row(8'd50, 3'd4, 1'b0);
			11'h100: m = row(8'd54, 3'd1, 1'b0);
			11'h110: m = row(8'd55, 3'd1, 1'b0);
			11'h120: m = row(8'd56, 3'd1, 1'b0);
			11'h130: m = row(8'd57, 3'd4, 1'b0);
			11'h135: m = row(8'd61, 3'd4, 1'b0);
			11'h140: m = row(8'd65, 3'd4, 1'b0);
			11'h145: m = row(8'd69, 3'd4, 1'b0);
			11'h000: m = row(8'd73, 3'd1, 1'b0);
			11'h010: m = row(8'd74, 3'd3, 1'b0);
			11'h020: m = row(8'd77, 3'd3, 1'b0);
			11'h011: m = row(8'd80, 3'd3, 1'b0);
			11'h021: m = row(8'd83, 3'd3, 1'b0);
			11'h150: m = row(8'd86, 3'd1, 1'b0);
			11'h160: m = row(8'd87, 3'd1, 1'b0);
			11'h170: m = row(8'd88, 3'd1, 1'b0);
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/cfvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfvt_ctrl
// Sequencer: accepts a transaction, steps the datapath through its table
// writes (known identifiers only) or its table read, then strobes the result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfvt_ctrl
	import cfvt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd,
	output logic         busy,
	output logic         done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						busy_q <= 1'b1;
						if (sts.in_rd) begin
							state_q <= S_READ;
						end else if (sts.in_known) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_RESP;
							done_q  <= 1'b1;
						end
					end
				end
				S_WRITE: begin
					if (sts.last_word) begin
						state_q <= S_RESP;
						done_q  <= 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_RESP;
					done_q  <= 1'b1;
				end
				S_RESP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load = (state_q == S_IDLE) && start;
		cmd.wr   = (state_q == S_WRITE);
		cmd.rd   = (state_q == S_READ);
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ rtl/core/cfvt_dp.sv @@
// ----------------------------------------------------------------------------
// cfvt_dp
// Datapath: transaction registers, identifier decode, word selection, the
// value table with per-entry valid bits, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cfvt_dp
	import cfvt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire item_t   item,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts,
	output result_t      result
);

	logic [15:0]      mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;

	map_t        map_in;
	map_t        map_q;
	logic [15:0] word_q [4];
	logic [7:0]  idx_q;
	logic [1:0]  k_q;
	logic [15:0] rval_q;
	logic [15:0] wdata;
	logic [7:0]  waddr;
	logic [7:0]  step;
	logic        idx_ok;

	assign map_in = map_lookup(item.can_id);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			map_q     <= (item.op == OP_READ) ? map_t'('0) : map_in;
			word_q[0] <= {item.byte1, item.byte0};
			word_q[1] <= {item.byte3, item.byte2};
			word_q[2] <= {item.byte5, item.byte4};
			word_q[3] <= {item.byte7, item.byte6};
			idx_q     <= item.read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 2'd0;
		end else if (cmd.load) begin
			k_q <= 2'd0;
		end else if (cmd.wr) begin
			k_q <= k_q + 2'd1;
		end
	end

	// Entry offset is k, or 2k for the two-word spaced identifiers
	assign step  = map_q.sp2 ? {5'd0, k_q, 1'b0} : {6'd0, k_q};
	assign waddr = map_q.first + step;
	assign wdata = word_q[k_q];

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[waddr[TBL_AW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.wr) begin
			vld_q[waddr[TBL_AW-1:0]] <= 1'b1;
		end
	end

	assign idx_ok = ({1'b0, idx_q} < 9'(TABLE_DEPTH));

	// Clear on load so frames report zero; fill on the read step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rval_q <= 16'd0;
		end else if (cmd.rd) begin
			rval_q <= (idx_ok && vld_q[idx_q[TBL_AW-1:0]]) ? mem[idx_q[TBL_AW-1:0]] : 16'd0;
		end
	end

	always_comb begin
		sts.in_rd     = (item.op == OP_READ);
		sts.in_known  = map_in.known;
		sts.last_word = ({1'b0, k_q} == (map_q.count - 3'd1));
	end

	always_comb begin
		result.id_known      = map_q.known;
		result.first_entry   = map_q.first;
		result.words_written = map_q.count;
		result.read_value    = rval_q;
	end

endmodule

`default_nettype wire

@@ rtl/core/can_frame_to_value_table_top.sv @@
// ----------------------------------------------------------------------------
// can_frame_to_value_table_top
// Stores CAN frame payloads in a 16-bit value table and serves entry reads.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item and raise start; the transaction is taken at a rising edge
//   with start high and busy low. item.op selects a received frame (the
//   identifier map picks the entries for its four little-endian words) or a
//   read of entry item.read_index.
//   The result appears on result for exactly one cycle with done high and
//   is taken at the edge that ends that cycle; the receiver cannot stall it.
//   Timing: a frame with n mapped words (1 to 4) takes n table writes, one
//   per cycle through the single write port, then one result cycle with
//   done high. Unknown identifiers go straight to the result cycle; reads
//   make one registered memory read before it. busy stays high until the
//   result cycle ends, so no new transaction is taken before then.
//   Reset clears all per-entry valid bits at once, so every entry reads as
//   zero until written; no clearing pass is needed and busy is low after
//   reset.
// ----------------------------------------------------------------------------
`default_nettype none

module can_frame_to_value_table_top
	import cfvt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire item_t item,
	output logic       busy,
	output logic       done,
	output result_t    result
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	cfvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cfvt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a transaction");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised after accept");

	a_frame_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.id_known) |-> (result.read_value == 16'd0))
		else $error("frame result carries read data");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.id_known) |->
		(result.words_written == 3'd0 && result.first_entry == 8'd0))
		else $error("write report without a matched identifier");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CAN frame to value table block. A queue of
// frames and entry reads, first hand-picked corner cases and then random
// traffic, drives the command port with random gaps. A shadow copy of the
// value table predicts every result, and a monitor compares each done strobe
// against the oldest prediction field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import cfvt_pkg::*;

	localparam int ROUTE_CNT   = 30;
	localparam int RAND_ITEMS  = 1350;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP   = 100;

	// {can id, first entry, word count, entry stride}
	typedef struct packed {
		logic [10:0] id;
		logic [7:0]  first;
		logic [2:0]  count;
		logic [1:0]  stride;
	} id_route_t;

	localparam logic [23:0] ROUTES [ROUTE_CNT] = '{
		{11'h030, 8'd1,  3'd4, 2'd1}, {11'h031, 8'd5,  3'd4, 2'd1},
		{11'h032, 8'd9,  3'd4, 2'd1}, {11'h040, 8'd13, 3'd4, 2'd1},
		{11'h041, 8'd17, 3'd4, 2'd1}, {11'h042, 8'd21, 3'd4, 2'd1},
		{11'h050, 8'd25, 3'd2, 2'd2}, {11'h060, 8'd26, 3'd2, 2'd2},
		{11'h070, 8'd29, 3'd1, 2'd1}, {11'h080, 8'd30, 3'd4, 2'd1},
		{11'h081, 8'd34, 3'd4, 2'd1}, {11'h082, 8'd38, 3'd4, 2'd1},
		{11'h090, 8'd42, 3'd4, 2'd1}, {11'h091, 8'd46, 3'd4, 2'd1},
		{11'h092, 8'd50, 3'd4, 2'd1}, {11'h100, 8'd54, 3'd1, 2'd1},
		{11'h110, 8'd55, 3'd1, 2'd1}, {11'h120, 8'd56, 3'd1, 2'd1},
		{11'h130, 8'd57, 3'd4, 2'd1}, {11'h135, 8'd61, 3'd4, 2'd1},
		{11'h140, 8'd65, 3'd4, 2'd1}, {11'h145, 8'd69, 3'd4, 2'd1},
		{11'h000, 8'd73, 3'd1, 2'd1}, {11'h010, 8'd74, 3'd3, 2'd1},
		{11'h020, 8'd77, 3'd3, 2'd1}, {11'h011, 8'd80, 3'd3, 2'd1},
		{11'h021, 8'd83, 3'd3, 2'd1}, {11'h150, 8'd86, 3'd1, 2'd1},
		{11'h160, 8'd87, 3'd1, 2'd1}, {11'h170, 8'd88, 3'd1, 2'd1}
	};

	typedef struct {
		item_t it;
		bit    drain;
	} cmd_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;

	logic [15:0] mirror_table [TABLE_DEPTH];
	cmd_t        cmd_queue[$];
	result_t     pending_results[$];
	cmd_t        cur_cmd;
	result_t     exp_res;
	logic        took;
	int          gap_left;
	int          burst_left;
	int          cycle_cnt;
	int          err_cnt;
	int          frames_known;
	int          frames_unknown;
	int          reads_done;
	int          results_checked;

	can_frame_to_value_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Update the shadow table and return what the block should answer
	function automatic result_t predict_table_access(input item_t it);
		result_t     r;
		logic [15:0] w [4];
		id_route_t   rt;
		r = '0;
		if (op_t'(it.op) == OP_READ) begin
			if (int'(it.read_index) < TABLE_DEPTH)
				r.read_value = mirror_table[it.read_index];
			return r;
		end
		w[0] = {it.byte1, it.byte0};
		w[1] = {it.byte3, it.byte2};
		w[2] = {it.byte5, it.byte4};
		w[3] = {it.byte7, it.byte6};
		for (int i = 0; i < ROUTE_CNT; i++) begin
			rt = id_route_t'(ROUTES[i]);
			if (rt.id == it.can_id) begin
				for (int k = 0; k < int'(rt.count); k++)
					if (int'(rt.first) + k * int'(rt.stride) < TABLE_DEPTH)
						mirror_table[int'(rt.first) + k * int'(rt.stride)] = w[k];
				r.id_known      = 1'b1;
				r.first_entry   = rt.first;
				r.words_written = rt.count;
				break;
			end
		end
		return r;
	endfunction

	function automatic int next_gap();
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		// now and then run a back-to-back stretch
		if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_cnt < PRINT_CAP)
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	task automatic add_frame(input logic [10:0] id, input logic [63:0] data,
			input bit drain);
		cmd_t c;
		c.it            = '0;
		c.it.op         = OP_FRAME;
		c.it.can_id     = id;
		{c.it.byte7, c.it.byte6, c.it.byte5, c.it.byte4,
			c.it.byte3, c.it.byte2, c.it.byte1, c.it.byte0} = data;
		c.it.read_index = 8'($urandom);
		c.drain         = drain;
		cmd_queue.push_back(c);
	endtask

	task automatic add_read(input logic [7:0] idx, input bit drain);
		cmd_t c;
		c.it            = '0;
		c.it.op         = OP_READ;
		c.it.can_id     = 11'($urandom);
		{c.it.byte7, c.it.byte6, c.it.byte5, c.it.byte4,
			c.it.byte3, c.it.byte2, c.it.byte1, c.it.byte0} = {$urandom, $urandom};
		c.it.read_index = idx;
		c.drain         = drain;
		cmd_queue.push_back(c);
	endtask

	// Driver: hold an offered transaction until taken, then gap and offer the next
	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || took) begin
				if (start)
					gap_left = next_gap();
				if (gap_left != 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_queue.size() != 0 &&
						!(cmd_queue[0].drain && pending_results.size() != 0)) begin
					cur_cmd = cmd_queue.pop_front();
					item  <= cur_cmd.it;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check results first, then record the accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycle_cnt);
			$display("DONE: errors detected");
			$finish;
		end else begin
			cycle_cnt++;
			if (done) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing outstanding", 32'(result), 32'd0);
				end else begin
					exp_res = pending_results.pop_front();
					if (result.id_known !== exp_res.id_known)
						report_mismatch("id_known", 32'(result.id_known), 32'(exp_res.id_known));
					if (result.first_entry !== exp_res.first_entry)
						report_mismatch("first_entry", 32'(result.first_entry),
							32'(exp_res.first_entry));
					if (result.words_written !== exp_res.words_written)
						report_mismatch("words_written", 32'(result.words_written),
							32'(exp_res.words_written));
					if (result.read_value !== exp_res.read_value)
						report_mismatch("read_value", 32'(result.read_value),
							32'(exp_res.read_value));
				end
			end
			if (start && !busy) begin
				exp_res = predict_table_access(item);
				pending_results.push_back(exp_res);
				if (op_t'(item.op) == OP_READ)
					reads_done++;
				else if (exp_res.id_known)
					frames_known++;
				else
					frames_unknown++;
			end
			took <= start && !busy;
		end
	end

	initial begin
		int        kind;
		id_route_t rt;
		arst_n          = 1'b0;
		start           = 1'b0;
		item            = '0;
		gap_left        = 0;
		burst_left      = 0;
		cycle_cnt       = 0;
		err_cnt         = 0;
		frames_known    = 0;
		frames_unknown  = 0;
		reads_done      = 0;
		results_checked = 0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			mirror_table[i] = '0;

		// corner cases: empty table, all-ones and all-zeros payloads, every map shape
		add_read(8'd0, 1'b0);
		add_frame(11'h000, {64{1'b1}}, 1'b0);
		add_read(8'd73, 1'b0);
		add_frame(11'h145, 64'h0123_4567_89ab_cdef, 1'b0);
		add_read(8'd69, 1'b0);
		add_read(8'd72, 1'b0);
		add_frame(11'h050, 64'h5555_aaaa_8000_7fff, 1'b0);
		add_frame(11'h060, 64'h0000_ffff_0001_fffe, 1'b0);
		add_read(8'd25, 1'b0);
		add_read(8'd26, 1'b0);
		add_read(8'd27, 1'b0);
		add_read(8'd28, 1'b0);
		add_frame(11'h010, 64'hdead_beef_cafe_f00d, 1'b0);
		add_read(8'd76, 1'b0);
		add_read(8'd77, 1'b0);
		add_frame(11'h021, 64'h1111_2222_3333_4444, 1'b0);
		add_read(8'd85, 1'b0);
		add_frame(11'h170, 64'h0000_0000_0000_ff00, 1'b0);
		add_read(8'd88, 1'b0);
		add_read(8'd89, 1'b0);
		add_frame(11'h7ff, {64{1'b1}}, 1'b0);
		add_frame(11'h033, 64'h0f0f_0f0f_0f0f_0f0f, 1'b0);
		add_read(8'd255, 1'b0);
		add_frame(11'h030, {64{1'b1}}, 1'b0);
		add_frame(11'h030, 64'd0, 1'b1);
		add_read(8'd1, 1'b0);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				rt = id_route_t'(ROUTES[$urandom_range(0, ROUTE_CNT - 1)]);
				add_frame(rt.id, {$urandom, $urandom}, n % 300 == 0);
			end else if (kind < 65) begin
				add_frame(11'($urandom_range(0, 2047)), {$urandom, $urandom}, 1'b0);
			end else if (kind < 93) begin
				add_read(8'($urandom_range(0, 95)), n % 300 == 150);
			end else begin
				add_read(8'($urandom_range(0, 255)), 1'b0);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_queue.size() != 0 || start || pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("Covered %0d mapped frames, %0d unmapped frames and %0d entry reads",
			frames_known, frames_unknown, reads_done);
		$display("Checked %0d results over %0d cycles, %0d mismatches",
			results_checked, cycle_cnt, err_cnt);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
